[design/serial_transfer_scheduler_top_assert.svh]
// assertion macros for the serial transfer scheduler
// expects clk and rst in the scope of the module that includes it
`ifndef SERIAL_TRANSFER_SCHEDULER_TOP_ASSERT_SVH
`define SERIAL_TRANSFER_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication
`define STS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("serial_transfer_scheduler_top: assertion failed");

// next-cycle implication
`define STS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("serial_transfer_scheduler_top: assertion failed");

`endif

[design/sts_pkg.sv]
// shared types, constants and length encoding for the serial transfer scheduler
// no dependencies
`default_nettype none

package sts_pkg;

  localparam int CHANNELS  = 4;
  localparam int CH_BITS   = 2;
  localparam int BYTE_BITS = 8;
  localparam int LEN_BITS  = 7;
  localparam int MAX_LEN   = 128;

  typedef enum logic [1:0] {
    CMD_SUBMIT   = 2'd0,
    CMD_COMPLETE = 2'd1,
    CMD_TICK     = 2'd2
  } cmd_t;

  // maximum length encodes as zero
  function automatic logic [LEN_BITS-1:0] len_code(input logic [BYTE_BITS-1:0] count);
    logic [BYTE_BITS:0] wide;
    wide = {1'b0, count};
    return (wide == (BYTE_BITS+1)'(MAX_LEN)) ? '0 : count[LEN_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

[design/sts_time_unit.sv]
// shared time unit: fire time adder and due compare against now
// standalone, no package use
`default_nettype none

module sts_time_unit #(
  parameter int TIME_BITS = 48
) (
  input  logic [TIME_BITS-1:0] last_done,
  input  logic [TIME_BITS-1:0] delay,
  input  logic [TIME_BITS-1:0] now,
  input  logic [TIME_BITS-1:0] probe,
  output logic [TIME_BITS-1:0] fire,
  output logic                 due
);

  // zero delay means fire now, otherwise wraps modulo the time width
  assign fire = (delay == '0) ? now : last_done + delay;
  assign due  = !(now < probe);

endmodule

`default_nettype wire

[design/serial_transfer_scheduler_top.sv]
// serial transfer scheduler: sequencer, slot store and output register
// depends on sts_pkg, sts_time_unit and serial_transfer_scheduler_top_assert.svh
// a refused submit, busy tick or unknown command goes from DECODE to FINISH, an
//   accepted submit passes SUB_DECIDE, and complete and tick pass the due SCAN
// a new beat is taken only in IDLE; FINISH waits while the held result is not taken
// reset: bus idle, no slot pending, completion times zero, no result held
`default_nettype none

`include "serial_transfer_scheduler_top_assert.svh"

module serial_transfer_scheduler_top #(
  parameter int TIME_BITS = 48
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     command,
  input  logic [sts_pkg::CH_BITS-1:0]    channel,
  input  logic [TIME_BITS-1:0]           now,
  input  logic [TIME_BITS-1:0]           delay,
  input  logic [sts_pkg::BYTE_BITS-1:0]  out_bytes,
  input  logic [sts_pkg::BYTE_BITS-1:0]  in_bytes,
  input  logic                           wants_interrupt,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           accepted,
  output logic                           start_valid,
  output logic [sts_pkg::CH_BITS-1:0]    start_channel,
  output logic [sts_pkg::LEN_BITS-1:0]   start_out_len,
  output logic [sts_pkg::LEN_BITS-1:0]   start_in_len,
  output logic                           start_irq_enable,
  output logic                           done_valid,
  output logic [sts_pkg::CH_BITS-1:0]    done_channel
);

  import sts_pkg::*;

  localparam int IW = $clog2(CHANNELS);

  typedef enum logic [2:0] {
    IDLE,
    DECODE,
    SUB_DECIDE,
    SCAN,
    FINISH
  } state_t;

  state_t state;

  logic                 bus_busy;
  logic [IW-1:0]        active_channel;
  logic [CHANNELS-1:0]  pending;
  logic [TIME_BITS-1:0] slot_fire [CHANNELS];
  logic [BYTE_BITS-1:0] slot_ob   [CHANNELS];
  logic [BYTE_BITS-1:0] slot_ib   [CHANNELS];
  logic                 slot_irq  [CHANNELS];
  logic [TIME_BITS-1:0] last_done [CHANNELS];

  // captured beat
  cmd_t                 cmd_r;
  logic [CH_BITS-1:0]   ch_r;
  logic [TIME_BITS-1:0] now_r;
  logic [TIME_BITS-1:0] delay_r;
  logic [BYTE_BITS-1:0] ob_r;
  logic [BYTE_BITS-1:0] ib_r;
  logic                 irq_r;

  logic [TIME_BITS-1:0] fire_r;
  logic [IW-1:0]        idx;
  logic [IW-1:0]        cnt;

  // staged result
  logic                 r_acc;
  logic                 r_sv;
  logic [IW-1:0]        r_sch;
  logic [LEN_BITS-1:0]  r_sol;
  logic [LEN_BITS-1:0]  r_sil;
  logic                 r_sirq;
  logic                 r_dv;
  logic [IW-1:0]        r_dch;

  logic [IW-1:0]        ch_idx;
  logic                 ch_ok;
  logic                 refused;
  logic [IW-1:0]        idx_next;
  logic [IW-1:0]        scan_first;
  logic [TIME_BITS-1:0] probe;
  logic [TIME_BITS-1:0] fire;
  logic                 due;

  assign ch_idx  = IW'(ch_r);
  assign ch_ok   = {30'b0, ch_r} < 32'(CHANNELS);
  assign refused = !ch_ok || (ch_ok ? pending[ch_idx] : 1'b0) ||
                   (bus_busy && active_channel == ch_idx);

  assign idx_next   = (idx == IW'(CHANNELS-1)) ? '0 : idx + 1'b1;
  assign scan_first = !bus_busy ? '0 :
                      (active_channel == IW'(CHANNELS-1)) ? '0 : active_channel + 1'b1;

  assign probe    = (state == SCAN) ? slot_fire[idx] : fire_r;
  assign in_ready = (state == IDLE);

  sts_time_unit #(
    .TIME_BITS (TIME_BITS)
  ) u_time (
    .last_done (last_done[ch_idx]),
    .delay     (delay_r),
    .now       (now_r),
    .probe     (probe),
    .fire      (fire),
    .due       (due)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      bus_busy       <= 1'b0;
      active_channel <= '0;
      pending        <= '0;
      out_valid      <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        last_done[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready && state != FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            cmd_r   <= cmd_t'(command);
            ch_r    <= channel;
            now_r   <= now;
            delay_r <= delay;
            ob_r    <= out_bytes;
            ib_r    <= in_bytes;
            irq_r   <= wants_interrupt;
            r_acc   <= 1'b0;
            r_sv    <= 1'b0;
            r_sch   <= '0;
            r_sol   <= '0;
            r_sil   <= '0;
            r_sirq  <= 1'b0;
            r_dv    <= 1'b0;
            r_dch   <= '0;
            state   <= DECODE;
          end
        end
        DECODE: begin
          unique case (cmd_r)
            CMD_SUBMIT: begin
              if (refused) begin
                state <= FINISH;
              end else begin
                fire_r <= fire;
                r_acc  <= 1'b1;
                state  <= SUB_DECIDE;
              end
            end
            CMD_COMPLETE: begin
              if (bus_busy) begin
                last_done[active_channel] <= now_r;
                r_dv  <= 1'b1;
                r_dch <= active_channel;
              end
              bus_busy <= 1'b0;
              idx      <= scan_first;
              cnt      <= '0;
              state    <= SCAN;
            end
            CMD_TICK: begin
              idx   <= '0;
              cnt   <= '0;
              state <= bus_busy ? FINISH : SCAN;
            end
            default: begin
              state <= FINISH;
            end
          endcase
        end
        SUB_DECIDE: begin
          if (due && !bus_busy) begin
            bus_busy       <= 1'b1;
            active_channel <= ch_idx;
            r_sv           <= 1'b1;
            r_sch          <= ch_idx;
            r_sol          <= len_code(ob_r);
            r_sil          <= len_code(ib_r);
            r_sirq         <= irq_r;
          end else begin
            pending[ch_idx]   <= 1'b1;
            slot_fire[ch_idx] <= fire_r;
            slot_ob[ch_idx]   <= ob_r;
            slot_ib[ch_idx]   <= ib_r;
            slot_irq[ch_idx]  <= irq_r;
          end
          state <= FINISH;
        end
        SCAN: begin
          if (pending[idx] && due) begin
            pending[idx]   <= 1'b0;
            bus_busy       <= 1'b1;
            active_channel <= idx;
            r_sv           <= 1'b1;
            r_sch          <= idx;
            r_sol          <= len_code(slot_ob[idx]);
            r_sil          <= len_code(slot_ib[idx]);
            r_sirq         <= slot_irq[idx];
            state          <= FINISH;
          end else if (cnt == IW'(CHANNELS-1)) begin
            state <= FINISH;
          end else begin
            idx <= idx_next;
            cnt <= cnt + 1'b1;
          end
        end
        FINISH: begin
          if (!out_valid || out_ready) begin
            accepted         <= r_acc;
            start_valid      <= r_sv;
            start_channel    <= CH_BITS'(r_sch);
            start_out_len    <= r_sol;
            start_in_len     <= r_sil;
            start_irq_enable <= r_sirq;
            done_valid       <= r_dv;
            done_channel     <= CH_BITS'(r_dch);
            out_valid        <= 1'b1;
            state            <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `STS_ASSERT_NOW(a_busy_not_pending, bus_busy, !pending[active_channel])
  `STS_ASSERT_NOW(a_scan_bus_idle, state == SCAN, !bus_busy)
  `STS_ASSERT_NOW(a_quiet_start, out_valid && !start_valid,
                  start_channel == '0 && start_out_len == '0 && start_in_len == '0 &&
                  !start_irq_enable)
  `STS_ASSERT_NEXT(a_launch_claims_bus, state == SCAN && pending[idx] && due,
                   bus_busy && !pending[$past(idx)])

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 100ps
// testbench for serial_transfer_scheduler_top: queued requests, a slot scheduler
// predictor and a scoreboard, with random stalls on both handshakes
// depends on sts_pkg and the scheduler rtl
module testbench;
  import sts_pkg::*;

  localparam int NUM_CH       = CHANNELS;
  localparam int TBITS        = 48;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int RANDOM_ITEMS = 1250;
  localparam int TAIL_ITEMS   = 120;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;

  typedef logic [TBITS-1:0] stamp_t;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [CH_BITS-1:0]   chan;
    stamp_t               at;
    stamp_t               dly;
    logic [BYTE_BITS-1:0] ob;
    logic [BYTE_BITS-1:0] ib;
    logic                 irq;
  } request_t;

  typedef struct packed {
    logic                accepted;
    logic                start_valid;
    logic [CH_BITS-1:0]  start_channel;
    logic [LEN_BITS-1:0] start_out_len;
    logic [LEN_BITS-1:0] start_in_len;
    logic                start_irq_enable;
    logic                done_valid;
    logic [CH_BITS-1:0]  done_channel;
  } sched_result_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [1:0] command;
  logic [CH_BITS-1:0] channel;
  stamp_t now;
  stamp_t delay;
  logic [BYTE_BITS-1:0] out_bytes;
  logic [BYTE_BITS-1:0] in_bytes;
  logic wants_interrupt;
  logic out_valid;
  logic out_ready;
  logic accepted;
  logic start_valid;
  logic [CH_BITS-1:0] start_channel;
  logic [LEN_BITS-1:0] start_out_len;
  logic [LEN_BITS-1:0] start_in_len;
  logic start_irq_enable;
  logic done_valid;
  logic [CH_BITS-1:0] done_channel;

  // predictor state
  logic                 bus_on;
  logic [CH_BITS-1:0]   on_bus;
  logic                 waiting [NUM_CH];
  stamp_t               fire_at [NUM_CH];
  logic [BYTE_BITS-1:0] slot_ob [NUM_CH];
  logic [BYTE_BITS-1:0] slot_ib [NUM_CH];
  logic                 slot_irq [NUM_CH];
  stamp_t               done_at [NUM_CH];

  request_t      pending_q[$];
  sched_result_t result_q[$];

  int  item_total;
  int  beats_in;
  int  cycles;
  int  mismatches;
  int  send_gap;
  int  stall_left;
  int  hold_left;
  logic hold_done;
  logic in_taken;
  logic calm;

  serial_transfer_scheduler_top #(
    .TIME_BITS(TBITS)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .channel         (channel),
    .now             (now),
    .delay           (delay),
    .out_bytes       (out_bytes),
    .in_bytes        (in_bytes),
    .wants_interrupt (wants_interrupt),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .accepted        (accepted),
    .start_valid     (start_valid),
    .start_channel   (start_channel),
    .start_out_len   (start_out_len),
    .start_in_len    (start_in_len),
    .start_irq_enable(start_irq_enable),
    .done_valid      (done_valid),
    .done_channel    (done_channel)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [LEN_BITS-1:0] length_field(input logic [BYTE_BITS-1:0] count);
    return (count == BYTE_BITS'(MAX_LEN)) ? '0 : count[LEN_BITS-1:0];
  endfunction

  function automatic void put_on_bus(input int c, input logic [BYTE_BITS-1:0] ob,
                                     input logic [BYTE_BITS-1:0] ib, input logic irq,
                                     inout sched_result_t r);
    bus_on = 1'b1;
    on_bus = CH_BITS'(c);
    r.start_valid      = 1'b1;
    r.start_channel    = CH_BITS'(c);
    r.start_out_len    = length_field(ob);
    r.start_in_len     = length_field(ib);
    r.start_irq_enable = irq;
  endfunction

  function automatic void launch_slot(input int c, inout sched_result_t r);
    waiting[c] = 1'b0;
    put_on_bus(c, slot_ob[c], slot_ib[c], slot_irq[c], r);
  endfunction

  function automatic sched_result_t schedule_step(input request_t rq);
    sched_result_t r;
    stamp_t fire;
    int base;
    int c;
    logic found;
    r = '0;
    found = 1'b0;
    case (rq.cmd)
      CMD_SUBMIT: begin
        if (!waiting[rq.chan] && !(bus_on && on_bus == rq.chan)) begin
          r.accepted = 1'b1;
          fire = (rq.dly == '0) ? rq.at : done_at[rq.chan] + rq.dly;
          if (!(rq.at < fire) && !bus_on) begin
            put_on_bus(int'(rq.chan), rq.ob, rq.ib, rq.irq, r);
          end else begin
            waiting[rq.chan]  = 1'b1;
            fire_at[rq.chan]  = fire;
            slot_ob[rq.chan]  = rq.ob;
            slot_ib[rq.chan]  = rq.ib;
            slot_irq[rq.chan] = rq.irq;
          end
        end
      end
      CMD_COMPLETE: begin
        base = NUM_CH - 1;
        if (bus_on) begin
          done_at[on_bus] = rq.at;
          r.done_valid    = 1'b1;
          r.done_channel  = on_bus;
          base            = int'(on_bus);
        end
        bus_on = 1'b0;
        for (int i = 1; i <= NUM_CH; i++) begin
          c = (base + i) % NUM_CH;
          if (!found && waiting[c] && fire_at[c] <= rq.at) begin
            found = 1'b1;
            launch_slot(c, r);
          end
        end
      end
      CMD_TICK: begin
        if (!bus_on) begin
          for (int i = 0; i < NUM_CH; i++) begin
            if (!found && waiting[i] && fire_at[i] <= rq.at) begin
              found = 1'b1;
              launch_slot(i, r);
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic string result_text(input sched_result_t r);
    return $sformatf("acc=%0d start=%0d ch=%0d out=%0d in=%0d irq=%0d done=%0d dch=%0d",
                     r.accepted, r.start_valid, r.start_channel, r.start_out_len,
                     r.start_in_len, r.start_irq_enable, r.done_valid, r.done_channel);
  endfunction

  function automatic stamp_t rand_stamp();
    return stamp_t'({$urandom(), $urandom()});
  endfunction

  function automatic logic [BYTE_BITS-1:0] rand_count();
    case ($urandom_range(0, 9))
      0: return 8'd1;
      1: return 8'd128;
      2: return 8'd127;
      default: return BYTE_BITS'($urandom_range(1, 128));
    endcase
  endfunction

  task automatic queue_item(input logic [1:0] cmd, input int chan, input stamp_t at,
                            input stamp_t dly, input int ob, input int ib, input bit irq);
    request_t rq;
    rq.cmd  = cmd;
    rq.chan = CH_BITS'(chan);
    rq.at   = at;
    rq.dly  = dly;
    rq.ob   = BYTE_BITS'(ob);
    rq.ib   = BYTE_BITS'(ib);
    rq.irq  = irq;
    pending_q.push_back(rq);
  endtask

  // sender: next beat offered at the falling edge once the last one is taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        command         <= pending_q[0].cmd;
        channel         <= pending_q[0].chan;
        now             <= pending_q[0].at;
        delay           <= pending_q[0].dly;
        out_bytes       <= pending_q[0].ob;
        in_bytes        <= pending_q[0].ib;
        wants_interrupt <= pending_q[0].irq;
        in_valid        <= 1'b1;
        void'(pending_q.pop_front());
        if (!calm && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 5);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: short random stalls plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && beats_in >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // scoreboard: results checked and requests predicted at the rising edge
  always @(posedge clk) begin
    request_t rq;
    sched_result_t seen;
    sched_result_t want;
    if (rst) begin
      in_taken <= 1'b0;
      bus_on = 1'b0;
      on_bus = '0;
      for (int i = 0; i < NUM_CH; i++) begin
        waiting[i]  = 1'b0;
        fire_at[i]  = '0;
        slot_ob[i]  = '0;
        slot_ib[i]  = '0;
        slot_irq[i] = 1'b0;
        done_at[i]  = '0;
      end
    end else begin
      cycles   <= cycles + 1;
      in_taken <= in_valid && in_ready;
      calm     <= pending_q.size() < TAIL_ITEMS;
      if (cycles >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("** serial_transfer_scheduler_top: FAILED **");
        $finish;
      end else begin
        if (out_valid && out_ready) begin
          seen = {accepted, start_valid, start_channel, start_out_len, start_in_len,
                  start_irq_enable, done_valid, done_channel};
          if (result_q.size() == 0) begin
            if (mismatches < 10) $display("unexpected result: %s", result_text(seen));
            mismatches++;
          end else begin
            want = result_q.pop_front();
            if (want !== seen) begin
              if (mismatches < 10) begin
                $display("mismatch at cycle %0d", cycles);
                $display("  expected %s", result_text(want));
                $display("  actual   %s", result_text(seen));
              end
              mismatches++;
            end
          end
        end
        if (in_valid && in_ready) begin
          rq = '{command, channel, now, delay, out_bytes, in_bytes, wants_interrupt};
          result_q.push_back(schedule_step(rq));
          beats_in <= beats_in + 1;
        end
      end
    end
  end

  initial begin
    stamp_t tnow;
    stamp_t at;
    stamp_t dly;
    int made;
    int roll;
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    command = CMD_SUBMIT;
    channel = '0;
    now = '0;
    delay = '0;
    out_bytes = 8'd1;
    in_bytes = 8'd1;
    wants_interrupt = 1'b0;
    beats_in = 0;
    cycles = 0;
    mismatches = 0;
    send_gap = 0;
    stall_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    in_taken = 1'b0;
    calm = 1'b0;

    // directed: refusals, wrap of fire time, round robin wrap, idle completion
    queue_item(CMD_SUBMIT,   0, 0,   0, 128, 1, 1);
    queue_item(CMD_SUBMIT,   0, 1,   0, 5, 5, 0);
    queue_item(CMD_SUBMIT,   1, 2,   0, 1, 128, 0);
    queue_item(CMD_TICK,     0, 3,   0, 1, 1, 0);
    queue_item(CMD_SUBMIT,   2, 4, 100, 64, 65, 1);
    queue_item(CMD_SUBMIT,   2, 5,   0, 3, 3, 0);
    queue_item(CMD_COMPLETE, 0, 10,  0, 1, 1, 0);
    queue_item(CMD_COMPLETE, 0, 20,  0, 1, 1, 0);
    queue_item(CMD_TICK,     0, 99,  0, 1, 1, 0);
    queue_item(CMD_TICK,     0, 100, 0, 1, 1, 0);
    queue_item(CMD_COMPLETE, 0, '1,  0, 1, 1, 0);
    queue_item(CMD_SUBMIT,   2, 5,   1, 127, 2, 1);
    queue_item(CMD_COMPLETE, 0, 6,   0, 1, 1, 0);
    queue_item(CMD_COMPLETE, 0, 7,   0, 1, 1, 0);
    queue_item(CMD_SUBMIT,   3, '1, '1, 127, 128, 0);
    queue_item(CMD_NONE,     3, '1, '1, 128, 128, 1);
    queue_item(CMD_SUBMIT,   0, 50, 500, 10, 20, 1);
    queue_item(CMD_SUBMIT,   1, 50,  0, 30, 40, 0);
    queue_item(CMD_COMPLETE, 0, 600, 0, 1, 1, 0);
    queue_item(CMD_COMPLETE, 0, 601, 0, 1, 1, 0);
    queue_item(CMD_SUBMIT,   0, 700, 0, 2, 3, 1);
    queue_item(CMD_SUBMIT,   3, 700, 0, 4, 5, 0);
    queue_item(CMD_COMPLETE, 0, 0,   0, 1, 1, 0);
    queue_item(CMD_TICK,     0, 800, 0, 1, 1, 0);
    queue_item(CMD_COMPLETE, 0, 801, 0, 1, 1, 0);

    // random: mostly a steadily advancing clock, now and then a jump or a wrap
    tnow = 1000;
    made = 0;
    while (made < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 299) == 0) tnow = '1 - stamp_t'($urandom_range(0, 300));
      tnow = tnow + stamp_t'($urandom_range(0, 24));
      at = ($urandom_range(0, 19) == 0) ? rand_stamp() : tnow;
      case ($urandom_range(0, 9))
        0, 1, 2: dly = '0;
        8: dly = rand_stamp();
        9: dly = '1 - stamp_t'($urandom_range(0, 60));
        default: dly = stamp_t'($urandom_range(1, 60));
      endcase
      if (roll < 4) begin
        queue_item(CMD_NONE, $urandom_range(0, 3), rand_stamp(), rand_stamp(),
                   rand_count(), rand_count(), $urandom_range(0, 1));
      end else begin
        queue_item((roll < 45) ? CMD_SUBMIT : (roll < 75) ? CMD_COMPLETE : CMD_TICK,
                   $urandom_range(0, 3), at, dly, rand_count(), rand_count(),
                   $urandom_range(0, 1));
        made++;
      end
    end
    item_total = pending_q.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (beats_in < item_total) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("** serial_transfer_scheduler_top: PASSED **");
    end else begin
      $display("** serial_transfer_scheduler_top: FAILED **");
    end
    $finish;
  end

endmodule
